// File: rtl/s2c_pkg.sv
// Shared widths, pipeline layout, palette codes and palette tables for the color ramp.
package s2c_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int CH_W    = 8;
  localparam int DIFF_W  = VALUE_WIDTH + 1;
  localparam int POS_W   = VALUE_WIDTH + 3;
  localparam int ACC_W   = VALUE_WIDTH + CH_W;
  localparam int PROD_W  = ACC_W + 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int PSEL_W  = 3;

  localparam int NORM_ST = 4;
  localparam int LERP_ST = 3;
  localparam int DIV_ST  = CH_W;
  localparam int NSTAGE  = NORM_ST + LERP_ST + DIV_ST;

  localparam logic [VALUE_WIDTH-1:0] SPAN_ONE =
    {{(VALUE_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Register indexes (byte address is 4x the index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PALETTE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

  localparam logic [PSEL_W-1:0] PAL_RAINBOW = 3'd0;
  localparam logic [PSEL_W-1:0] PAL_TRAFFIC = 3'd1;
  localparam logic [PSEL_W-1:0] PAL_BLUERED = 3'd2;
  localparam logic [PSEL_W-1:0] PAL_HEAT    = 3'd3;
  localparam logic [PSEL_W-1:0] PAL_COOL    = 3'd4;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  localparam rgb_t WHITE = {8'd255, 8'd255, 8'd255};

  typedef struct packed {
    logic [PSEL_W-1:0]      palette_select;
    logic [VALUE_WIDTH-1:0] range_low;
    logic [VALUE_WIDTH-1:0] range_high;
  } cfg_t;

  // Result of the normalize/segment stages.
  typedef struct packed {
    logic [PSEL_W-1:0]      pal;
    logic [2:0]             idx;
    logic [POS_W-1:0]       pos;
    logic [VALUE_WIDTH-1:0] den;
    logic [POS_W-1:0]       den_x2;
    logic [POS_W-1:0]       den_x3;
    logic [POS_W-1:0]       den_x4;
  } norm_t;

  // Interpolation numerators per channel (r, g, b from high to low) and the span.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0]      den;
    logic [2:0][ACC_W-1:0]       acc;
  } lerp_t;

  // Number of segments (palette length minus one); unknown palettes map to white.
  function automatic logic [2:0] pal_segs(input logic [PSEL_W-1:0] sel);
    logic [2:0] n;
    unique case (sel)
      PAL_RAINBOW: n = 3'd5;
      PAL_HEAT:    n = 3'd3;
      default:     n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic rgb_t pal_color(input logic [PSEL_W-1:0] sel, input logic [2:0] k);
    rgb_t c;
    c = WHITE;
    unique case (sel)
      PAL_RAINBOW: begin
        unique case (k)
          3'd0:    c = {8'd255, 8'd0,   8'd0};
          3'd1:    c = {8'd255, 8'd127, 8'd0};
          3'd2:    c = {8'd255, 8'd255, 8'd0};
          3'd3:    c = {8'd0,   8'd255, 8'd0};
          3'd4:    c = {8'd0,   8'd255, 8'd255};
          default: c = {8'd0,   8'd0,   8'd255};
        endcase
      end
      PAL_TRAFFIC: begin
        unique case (k)
          3'd0:    c = {8'd255, 8'd0,   8'd0};
          3'd1:    c = {8'd255, 8'd255, 8'd0};
          default: c = {8'd0,   8'd255, 8'd0};
        endcase
      end
      PAL_BLUERED: begin
        unique case (k)
          3'd0:    c = {8'd0,   8'd0,   8'd255};
          3'd1:    c = WHITE;
          default: c = {8'd255, 8'd0,   8'd0};
        endcase
      end
      PAL_HEAT: begin
        unique case (k)
          3'd0:    c = {8'd0,   8'd0,   8'd0};
          3'd1:    c = {8'd255, 8'd0,   8'd0};
          3'd2:    c = {8'd255, 8'd255, 8'd0};
          default: c = WHITE;
        endcase
      end
      PAL_COOL: begin
        unique case (k)
          3'd0:    c = {8'd0,   8'd255, 8'd255};
          3'd1:    c = {8'd0,   8'd0,   8'd255};
          default: c = {8'd128, 8'd0,   8'd128};
        endcase
      end
      default: c = WHITE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/s2c_stream_if.sv
// Valid/ready stream interfaces for the sample input and the color output.
interface s2c_sample_if import s2c_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface s2c_color_if import s2c_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/s2c_cfg.sv
// APB register file: palette select and the value range.
module s2c_cfg import s2c_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.palette_select <= PAL_RAINBOW;
      cfg.range_low      <= '0;
      cfg.range_high     <= SPAN_ONE;
    end else if (wr) begin
      unique case (reg_idx)
        REG_PALETTE:    cfg.palette_select <= pwdata[PSEL_W-1:0];
        REG_RANGE_LOW:  cfg.range_low      <= pwdata[VALUE_WIDTH-1:0];
        REG_RANGE_HIGH: cfg.range_high     <= pwdata[VALUE_WIDTH-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PALETTE:    prdata = DATA_W'(cfg.palette_select);
      REG_RANGE_LOW:  prdata = DATA_W'(cfg.range_low);
      REG_RANGE_HIGH: prdata = DATA_W'(cfg.range_high);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/s2c_pipe_ctrl.sv
// Stage valid bits and per-stage load enables; stalls collapse bubbles.
module s2c_pipe_ctrl import s2c_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic [NSTAGE-1:0] en,
  output logic              out_valid
);

  logic [NSTAGE-1:0] v;
  logic              in_take;
  logic              out_take;

  // A stage loads when it is empty or its contents move on.
  assign en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
  for (genvar i = 0; i < NSTAGE - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign out_valid = v[NSTAGE-1];
  assign in_take   = in_valid && en[0];
  assign out_take  = v[NSTAGE-1] && out_ready;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !en[0] |-> (v == {NSTAGE{1'b1}} && !out_ready))
    else $error("input stalled while pipeline has room");

  a_item_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      $countones(v) == $past($countones(v)) + $past(in_take) - $past(out_take))
    else $error("request lost or duplicated in pipeline");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (v[NSTAGE-1] && !out_ready) |=> v[NSTAGE-1])
    else $error("pending result dropped");

endmodule

// File: rtl/s2c_norm.sv
// Stages 0-3: offset and span, clamp, segment position, segment index.
module s2c_norm import s2c_pkg::*; (
  input  logic                   clk,
  input  logic [NORM_ST-1:0]     en,
  input  logic [VALUE_WIDTH-1:0] sample_value,
  input  cfg_t                   cfg,
  output norm_t                  result
);

  // stage 0
  logic signed [DIFF_W-1:0] span_diff;
  logic signed [DIFF_W-1:0] offs;
  logic [VALUE_WIDTH-1:0]   den0;
  logic [VALUE_WIDTH-1:0]   den0_q;
  logic [DIFF_W-1:0]        offs0_q;
  logic [PSEL_W-1:0]        pal0_q;

  // stage 1
  logic [VALUE_WIDTH-1:0]   num1;
  logic [VALUE_WIDTH-1:0]   num1_q;
  logic [VALUE_WIDTH-1:0]   den1_q;
  logic [PSEL_W-1:0]        pal1_q;

  // stage 2
  logic [2:0]               segs1;
  logic [POS_W-1:0]         pos1;
  logic [POS_W-1:0]         dx2;
  logic [POS_W-1:0]         dx3;
  logic [POS_W-1:0]         pos2_q;
  logic [VALUE_WIDTH-1:0]   den2_q;
  logic [POS_W-1:0]         dx2_q;
  logic [POS_W-1:0]         dx3_q;
  logic [POS_W-1:0]         dx4_q;
  logic [PSEL_W-1:0]        pal2_q;

  // stage 3
  logic [2:0]               whole;
  logic [2:0]               idx_max;
  logic [2:0]               idx;

  always_comb begin
    span_diff = DIFF_W'($signed(cfg.range_high)) - DIFF_W'($signed(cfg.range_low));
    offs      = DIFF_W'($signed(sample_value)) - DIFF_W'($signed(cfg.range_low));
    den0      = (span_diff > 0) ? span_diff[VALUE_WIDTH-1:0] : SPAN_ONE;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      den0_q  <= den0;
      offs0_q <= offs;
      pal0_q  <= cfg.palette_select;
    end
  end

  always_comb begin
    if (offs0_q[DIFF_W-1]) begin
      num1 = '0;
    end else if (offs0_q > {1'b0, den0_q}) begin
      num1 = den0_q;
    end else begin
      num1 = offs0_q[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num1_q <= num1;
      den1_q <= den0_q;
      pal1_q <= pal0_q;
    end
  end

  always_comb begin
    segs1 = pal_segs(pal1_q);
    pos1  = POS_W'(num1_q) * POS_W'(segs1);
    dx2   = POS_W'(den1_q) << 1;
    dx3   = POS_W'(den1_q) + dx2;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pos2_q <= pos1;
      den2_q <= den1_q;
      dx2_q  <= dx2;
      dx3_q  <= dx3;
      dx4_q  <= POS_W'(den1_q) << 2;
      pal2_q <= pal1_q;
    end
  end

  // floor(pos/den) from compares against the span multiples, then capped at the last segment
  always_comb begin
    idx_max = pal_segs(pal2_q) - 3'd1;
    priority if (pos2_q >= dx4_q)          whole = 3'd4;
    else if (pos2_q >= dx3_q)              whole = 3'd3;
    else if (pos2_q >= dx2_q)              whole = 3'd2;
    else if (pos2_q >= POS_W'(den2_q))     whole = 3'd1;
    else                                   whole = 3'd0;
    idx = (whole > idx_max) ? idx_max : whole;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      result.pal    <= pal2_q;
      result.idx    <= idx;
      result.pos    <= pos2_q;
      result.den    <= den2_q;
      result.den_x2 <= dx2_q;
      result.den_x3 <= dx3_q;
      result.den_x4 <= dx4_q;
    end
  end

endmodule

// File: rtl/s2c_lerp.sv
// Stages 4-6: segment remainder, palette lookup, interpolation numerators.
module s2c_lerp import s2c_pkg::*; (
  input  logic               clk,
  input  logic [LERP_ST-1:0] en,
  input  norm_t              norm,
  output lerp_t              result
);

  // stage 4
  logic [POS_W-1:0]           base;
  logic [POS_W-1:0]           rem_full;
  rgb_t                       c_lo;
  rgb_t                       c_hi;
  logic [2:0][CH_W-1:0]       lo_ch;
  logic [2:0][CH_W-1:0]       hi_ch;
  logic [2:0][CH_W:0]         delta;
  logic [VALUE_WIDTH-1:0]     rem4_q;
  logic [VALUE_WIDTH-1:0]     den4_q;
  logic [2:0][CH_W-1:0]       c1_q;
  logic [2:0][CH_W:0]         d_q;

  // stage 5
  logic [2:0][ACC_W-1:0]      p1;
  logic [2:0][PROD_W-1:0]     p2;
  logic [2:0][ACC_W-1:0]      p1_q;
  logic [2:0][PROD_W-1:0]     p2_q;
  logic [VALUE_WIDTH-1:0]     den5_q;

  // stage 6
  logic [2:0][PROD_W-1:0]     sum;

  always_comb begin
    unique case (norm.idx)
      3'd0:    base = '0;
      3'd1:    base = POS_W'(norm.den);
      3'd2:    base = norm.den_x2;
      3'd3:    base = norm.den_x3;
      3'd4:    base = norm.den_x4;
      default: base = '0;
    endcase
    rem_full = norm.pos - base;
    c_lo     = pal_color(norm.pal, norm.idx);
    c_hi     = pal_color(norm.pal, norm.idx + 3'd1);
    lo_ch    = c_lo;
    hi_ch    = c_hi;
    for (int ch = 0; ch < 3; ch++) begin
      delta[ch] = {1'b0, hi_ch[ch]} - {1'b0, lo_ch[ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem4_q <= rem_full[VALUE_WIDTH-1:0];
      den4_q <= norm.den;
      c1_q   <= lo_ch;
      d_q    <= delta;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p1[ch] = ACC_W'(c1_q[ch]) * ACC_W'(den4_q);
      p2[ch] = PROD_W'($signed({1'b0, rem4_q})) * PROD_W'($signed(d_q[ch]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_q   <= p1;
      p2_q   <= p2;
      den5_q <= den4_q;
    end
  end

  // c1*den + rem*(c2-c1) lies in [0, 256*den), so it fits ACC_W unsigned
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = $signed({2'b00, p1_q[ch]}) + $signed(p2_q[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      result.den <= den5_q;
      for (int ch = 0; ch < 3; ch++) begin
        result.acc[ch] <= sum[ch][ACC_W-1:0];
      end
    end
  end

endmodule

// File: rtl/s2c_div.sv
// Stages 7-14: restoring divide, one quotient bit per stage for all three channels.
module s2c_div import s2c_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_ST-1:0]    en,
  input  lerp_t                lerp,
  output logic [2:0][CH_W-1:0] color
);

  logic [2:0][ACC_W-1:0]  rin  [DIV_ST];
  logic [VALUE_WIDTH-1:0] din  [DIV_ST];
  logic [2:0][CH_W-1:0]   qin  [DIV_ST];
  logic [2:0][ACC_W-1:0]  rout [DIV_ST];
  logic [2:0][CH_W-1:0]   qout [DIV_ST];
  logic [ACC_W-1:0]       trial[DIV_ST];

  logic [2:0][ACC_W-1:0]  rem_q [DIV_ST-1];
  logic [VALUE_WIDTH-1:0] den_q [DIV_ST-1];
  logic [2:0][CH_W-1:0]   quo_q [DIV_ST];

  assign rin[0] = lerp.acc;
  assign din[0] = lerp.den;
  assign qin[0] = '0;

  for (genvar k = 0; k < DIV_ST; k++) begin : g_step
    localparam int B = DIV_ST - 1 - k;

    if (k > 0) begin : g_link
      assign rin[k] = rem_q[k-1];
      assign din[k] = den_q[k-1];
      assign qin[k] = quo_q[k-1];
    end

    assign trial[k] = ACC_W'(din[k]) << B;

    always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rin[k][ch] >= trial[k]) begin
          rout[k][ch] = rin[k][ch] - trial[k];
          qout[k][ch] = qin[k][ch] | (CH_W'(1) << B);
        end else begin
          rout[k][ch] = rin[k][ch];
          qout[k][ch] = qin[k][ch];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) quo_q[k] <= qout[k];
    end

    if (k < DIV_ST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_q[k] <= rout[k];
          den_q[k] <= din[k];
        end
      end
    end
  end

  assign color = quo_q[DIV_ST-1];

endmodule

// File: rtl/scalar_to_color_ramp_core.sv
// Color ramp lookup: signed fixed-point scalar in, interpolated RGB color out.
// Accepts one sample per cycle unless stalled, and returns one color per sample
// in order. The 15 register stages are the range normalization and segment search
// (4), palette lookup and interpolation products (3), and an 8-stage quotient
// pipeline that divides the three channel numerators by the range span one bit
// per stage; the last of these is the output register. When the output stalls,
// empty stages still fill, so the input keeps taking requests until every stage
// holds one. Configuration must be written over APB (palette 0x0, range low 0x4,
// range high 0x8) only while the block is idle; the block does not enforce this.
module scalar_to_color_ramp_core import s2c_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  s2c_sample_if.sink        samples,
  s2c_color_if.source       colors,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                 cfg;
  logic [NSTAGE-1:0]    en;
  norm_t                norm;
  lerp_t                lerp;
  logic [2:0][CH_W-1:0] color;

  s2c_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  s2c_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .out_ready (colors.ready),
    .en        (en),
    .out_valid (colors.valid)
  );

  assign samples.ready = en[0];

  s2c_norm u_norm (
    .clk          (clk),
    .en           (en[NORM_ST-1:0]),
    .sample_value (samples.sample_value),
    .cfg          (cfg),
    .result       (norm)
  );

  s2c_lerp u_lerp (
    .clk    (clk),
    .en     (en[NORM_ST+LERP_ST-1:NORM_ST]),
    .norm   (norm),
    .result (lerp)
  );

  s2c_div u_div (
    .clk   (clk),
    .en    (en[NSTAGE-1:NORM_ST+LERP_ST]),
    .lerp  (lerp),
    .color (color)
  );

  assign colors.red   = color[2];
  assign colors.green = color[1];
  assign colors.blue  = color[0];

endmodule
